/* design/eld_pkg.sv */
// Shared types and codes for the ElGamal decryption core.
package eld_pkg;

	// Configuration register indexes.
	localparam int CFG_INDEX_BITS = 1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_MODULUS     = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PRIVATE_KEY = 1'b1;

	// Datapath operations.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_DIV_C1,
		OP_DIV_C2,
		OP_POW_INIT,
		OP_MUL_SQ,
		OP_MUL_BASE,
		OP_EU_INIT,
		OP_EU_DIV,
		OP_EU_MUL,
		OP_EU_UPD,
		OP_PT_MUL,
		OP_PUB,
		OP_PUB_SMALL
	} dp_op_t;

	// Controller states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RED1,
		ST_RED2,
		ST_PINIT,
		ST_SQ,
		ST_MB,
		ST_EINIT,
		ST_ECHK,
		ST_EDIV,
		ST_EMUL,
		ST_EUPD,
		ST_PTMUL,
		ST_PUB,
		ST_PUBS
	} ctrl_state_t;

	typedef struct packed {
		dp_op_t op;
		logic   exp_shift;
	} dp_cmd_t;

	typedef struct packed {
		logic done;
		logic m_small;
		logic c1_zero;
		logic exp_msb;
		logic r1_zero;
		logic r0_one;
	} dp_status_t;

endpackage

/* design/eld_dp.sv */
// Datapath: configuration, operand registers and a shared bit-serial divide/multiply unit.
module eld_dp import eld_pkg::*; #(
	parameter int W = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [W-1:0]              cfg_data,
	input  logic [W-1:0]              cipher_first,
	input  logic [W-1:0]              cipher_second,
	input  dp_cmd_t                   cmd,
	output dp_status_t                status,
	output logic [W-1:0]              plaintext,
	output logic [W-1:0]              shared_key,
	output logic                      no_inverse
);

	localparam int CW = $clog2(W);
	localparam logic [CW-1:0] LAST = CW'(W - 1);

	logic [W-1:0] mod_q, pkey_q;
	logic [W-1:0] c1_q, c2_q, key_q, exp_q;
	logic [W-1:0] r0_q, r1_q, t0_q, t1_q, quo_q, nr_q, prod_q, pt_q;
	logic [W-1:0] work_q, acc_q;
	logic [W-1:0] plaintext_q, shared_key_q;
	logic         no_inverse_q;
	logic         run_q;
	logic [CW-1:0] cnt_q;

	logic         is_multi, is_div, done;
	logic [W-1:0] op_a, op_d, load_work, quo_fix, nt;
	logic [W:0]   dv_t, dbl, sum;
	logic         dv_ge;
	logic [W-1:0] div_rem, div_quo, dbl_r, addend, mul_acc, mul_work;
	logic [W-1:0] acc_next, work_next;

	// Operation decode and operand selection.
	assign is_div = (cmd.op == OP_DIV_C1) || (cmd.op == OP_DIV_C2) || (cmd.op == OP_EU_DIV);
	assign is_multi = is_div || (cmd.op == OP_MUL_SQ) || (cmd.op == OP_MUL_BASE)
		|| (cmd.op == OP_EU_MUL) || (cmd.op == OP_PT_MUL);
	assign done = run_q && (cnt_q == LAST);
	assign quo_fix = (quo_q == mod_q) ? '0 : quo_q;
	// Coefficient update t0 - q*t1 kept in the range 0 to modulus minus one.
	assign nt = (t0_q >= prod_q) ? (t0_q - prod_q) : (t0_q + (mod_q - prod_q));

	always_comb begin
		op_a = key_q;
		op_d = mod_q;
		load_work = key_q;
		case (cmd.op)
			OP_DIV_C1: load_work = c1_q;
			OP_DIV_C2: load_work = c2_q;
			OP_MUL_BASE: load_work = c1_q;
			OP_EU_DIV: begin
				load_work = r0_q;
				op_d = r1_q;
			end
			OP_EU_MUL: begin
				load_work = quo_fix;
				op_a = t1_q;
			end
			OP_PT_MUL: begin
				load_work = t0_q;
				op_a = c2_q;
			end
			default: ;
		endcase
	end

	// One restoring-division step: shift in a dividend bit, subtract if it fits.
	assign dv_t = {acc_q, work_q[W-1]};
	assign dv_ge = dv_t >= {1'b0, op_d};
	assign div_rem = dv_ge ? W'(dv_t - {1'b0, op_d}) : dv_t[W-1:0];
	assign div_quo = {work_q[W-2:0], dv_ge};

	// One double-and-add step modulo the modulus.
	assign dbl = {acc_q, 1'b0};
	assign dbl_r = (dbl >= {1'b0, mod_q}) ? W'(dbl - {1'b0, mod_q}) : dbl[W-1:0];
	assign addend = work_q[W-1] ? op_a : '0;
	assign sum = {1'b0, dbl_r} + {1'b0, addend};
	assign mul_acc = (sum >= {1'b0, mod_q}) ? W'(sum - {1'b0, mod_q}) : sum[W-1:0];
	assign mul_work = {work_q[W-2:0], 1'b0};

	assign acc_next = is_div ? div_rem : mul_acc;
	assign work_next = is_div ? div_quo : mul_work;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= W'(2);
			pkey_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODULUS: mod_q <= cfg_data;
				REG_PRIVATE_KEY: pkey_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Bit counter of the serial unit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (is_multi) begin
			if (!run_q) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (done) begin
				run_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Operand and result registers.
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				c1_q <= cipher_first;
				c2_q <= cipher_second;
			end
			OP_POW_INIT: begin
				key_q <= (c1_q == '0) ? '0 : W'(1);
				exp_q <= pkey_q;
			end
			OP_EU_INIT: begin
				r0_q <= mod_q;
				r1_q <= key_q;
				t0_q <= '0;
				t1_q <= W'(1);
			end
			OP_EU_UPD: begin
				r0_q <= r1_q;
				r1_q <= nr_q;
				t0_q <= t1_q;
				t1_q <= nt;
			end
			OP_PUB: begin
				plaintext_q <= status.r0_one ? pt_q : '0;
				shared_key_q <= key_q;
				no_inverse_q <= !status.r0_one;
			end
			OP_PUB_SMALL: begin
				plaintext_q <= '0;
				shared_key_q <= '0;
				no_inverse_q <= 1'b1;
			end
			default: begin
				if (is_multi) begin
					if (!run_q) begin
						work_q <= load_work;
						acc_q <= '0;
					end else begin
						work_q <= work_next;
						acc_q <= acc_next;
					end
					if (done) begin
						case (cmd.op)
							OP_DIV_C1: c1_q <= acc_next;
							OP_DIV_C2: c2_q <= acc_next;
							OP_MUL_SQ, OP_MUL_BASE: key_q <= acc_next;
							OP_EU_DIV: begin
								quo_q <= work_next;
								nr_q <= acc_next;
							end
							OP_EU_MUL: prod_q <= acc_next;
							OP_PT_MUL: pt_q <= acc_next;
							default: ;
						endcase
					end
				end
			end
		endcase
		if (cmd.exp_shift) begin
			exp_q <= {exp_q[W-2:0], 1'b0};
		end
	end

	// Status to the controller.
	assign status.done = done;
	assign status.m_small = (mod_q[W-1:1] == '0);
	assign status.c1_zero = (c1_q == '0);
	assign status.exp_msb = exp_q[W-1];
	assign status.r1_zero = (r1_q == '0);
	assign status.r0_one = (r0_q == W'(1));

	assign plaintext = plaintext_q;
	assign shared_key = shared_key_q;
	assign no_inverse = no_inverse_q;

endmodule

/* design/eld_ctrl.sv */
// Controller: sequences reduction, exponentiation, Euclid inverse and the result handoff.
module eld_ctrl import eld_pkg::*; #(
	parameter int W = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	localparam int CW = $clog2(W);
	localparam logic [CW-1:0] LAST = CW'(W - 1);

	ctrl_state_t state_q, state_next;
	logic [CW-1:0] bit_q;
	logic          out_valid_q;
	logic          slot_free, last_bit, publish;

	assign slot_free = !out_valid_q || out_ready;
	assign last_bit = (bit_q == LAST);
	assign publish = (cmd.op == OP_PUB) || (cmd.op == OP_PUB_SMALL);

	// Next state.
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_next = status.m_small ? ST_PUBS : ST_RED1;
			ST_RED1: if (status.done) state_next = ST_RED2;
			ST_RED2: if (status.done) state_next = ST_PINIT;
			ST_PINIT: state_next = status.c1_zero ? ST_EINIT : ST_SQ;
			ST_SQ: begin
				if (status.done) begin
					if (status.exp_msb) state_next = ST_MB;
					else state_next = last_bit ? ST_EINIT : ST_SQ;
				end
			end
			ST_MB: if (status.done) state_next = last_bit ? ST_EINIT : ST_SQ;
			ST_EINIT: state_next = ST_ECHK;
			ST_ECHK: begin
				if (!status.r1_zero) state_next = ST_EDIV;
				else state_next = status.r0_one ? ST_PTMUL : ST_PUB;
			end
			ST_EDIV: if (status.done) state_next = ST_EMUL;
			ST_EMUL: if (status.done) state_next = ST_EUPD;
			ST_EUPD: state_next = ST_ECHK;
			ST_PTMUL: if (status.done) state_next = ST_PUB;
			ST_PUB, ST_PUBS: if (slot_free) state_next = ST_IDLE;
			default: state_next = ST_IDLE;
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		cmd.op = OP_NONE;
		cmd.exp_shift = 1'b0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd.op = OP_LOAD;
			end
			ST_RED1: cmd.op = OP_DIV_C1;
			ST_RED2: cmd.op = OP_DIV_C2;
			ST_PINIT: cmd.op = OP_POW_INIT;
			ST_SQ: begin
				cmd.op = OP_MUL_SQ;
				cmd.exp_shift = status.done && !status.exp_msb;
			end
			ST_MB: begin
				cmd.op = OP_MUL_BASE;
				cmd.exp_shift = status.done;
			end
			ST_EINIT: cmd.op = OP_EU_INIT;
			ST_EDIV: cmd.op = OP_EU_DIV;
			ST_EMUL: cmd.op = OP_EU_MUL;
			ST_EUPD: cmd.op = OP_EU_UPD;
			ST_PTMUL: cmd.op = OP_PT_MUL;
			ST_PUB: if (slot_free) cmd.op = OP_PUB;
			ST_PUBS: if (slot_free) cmd.op = OP_PUB_SMALL;
			default: ;
		endcase
	end

	// State, exponent bit count and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bit_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.op == OP_POW_INIT) bit_q <= '0;
			else if (cmd.exp_shift) bit_q <= bit_q + 1'b1;
			if (publish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* design/elgamal_decrypt_core.sv */
// Top level of the ElGamal decryption core.
//
//  Channel  Signals                                   Direction
//  in       in_valid/in_ready, cipher_first/second    item in
//  out      out_valid/out_ready, plaintext,            item out
//           shared_key, no_inverse
//  cfg      cfg_we, cfg_index, cfg_data               register write
//
// Every serial divide or multiply runs in the shared unit.
// An item goes through reduction, the power (for a nonzero base) and the Euclid rounds.
// One item is in flight; a new item is taken while the previous result waits.
// Reset clears control and sets modulus to 2, private key to 0.
module elgamal_decrypt_core import eld_pkg::*; #(
	parameter int WORD_BITS = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [WORD_BITS-1:0]      cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [WORD_BITS-1:0]      cipher_first,
	input  logic [WORD_BITS-1:0]      cipher_second,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [WORD_BITS-1:0]      plaintext,
	output logic [WORD_BITS-1:0]      shared_key,
	output logic                      no_inverse
);

	dp_cmd_t    cmd;
	dp_status_t status;

	eld_ctrl #(.W(WORD_BITS)) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.cmd(cmd)
	);

	eld_dp #(.W(WORD_BITS)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cipher_first(cipher_first),
		.cipher_second(cipher_second),
		.cmd(cmd),
		.status(status),
		.plaintext(plaintext),
		.shared_key(shared_key),
		.no_inverse(no_inverse)
	);

endmodule

/* design/eld_checker.sv */
// Port-level checks for the ElGamal decryption core, bound to the top level.
module eld_checker #(
	parameter int W = 32
) (
	input logic         clk,
	input logic         arst_n,
	input logic         in_valid,
	input logic         in_ready,
	input logic         out_valid,
	input logic         out_ready,
	input logic [W-1:0] plaintext,
	input logic [W-1:0] shared_key,
	input logic         no_inverse
);

	// A waiting result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(plaintext)
			&& $stable(shared_key) && $stable(no_inverse))
		else $error("result item changed while stalled");

	// No inverse means a zero plaintext.
	a_noinv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && no_inverse |-> plaintext == '0)
		else $error("plaintext nonzero without inverse");

	// An invertible key is never zero.
	a_key_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !no_inverse |-> shared_key != '0)
		else $error("zero key reported as invertible");

	// After an item is taken the block is busy.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken back to back");

endmodule

bind elgamal_decrypt_core eld_checker #(.W(WORD_BITS)) u_eld_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.plaintext(plaintext),
	.shared_key(shared_key),
	.no_inverse(no_inverse)
);

/* verif/tb_elgamal_decrypt_core.sv */
// Self-checking testbench for the ElGamal decryption core with a scoreboard class.
`timescale 1ns / 100ps

// Holds the expected decryptions and compares each returned item against them.
class decrypt_scoreboard;
	typedef struct packed {
		logic [31:0] plain;
		logic [31:0] key;
		logic        no_inv;
	} decrypt_result_t;

	decrypt_result_t pending_results[$];
	logic [31:0]     modulus_q;
	logic [31:0]     secret_x;
	int              mismatch_count;
	int              checked_count;
	int              no_inverse_seen;

	function new();
		modulus_q = 32'd2;
		secret_x = 32'd0;
		mismatch_count = 0;
		checked_count = 0;
		no_inverse_seen = 0;
	endfunction

	// Modular product in 64-bit arithmetic; both factors are below the modulus.
	function automatic logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
		return (a * b) % m;
	endfunction

	// Works out one decryption from the current register values.
	function automatic decrypt_result_t decrypt(logic [31:0] c1_raw, logic [31:0] c2_raw);
		decrypt_result_t res;
		logic [63:0] m, c1, c2, k;
		logic [63:0] r0, r1, t0, t1, qt, nr, nt, pt;
		m = {32'd0, modulus_q};
		res = '0;
		if (m < 2) begin
			res.no_inv = 1'b1;
			return res;
		end
		c1 = c1_raw % m;
		c2 = c2_raw % m;
		// Shared key by square and multiply; a zero base always gives zero.
		if (c1 == 0) begin
			k = 0;
		end else begin
			k = 1;
			for (int i = 31; i >= 0; i--) begin
				k = mul_mod(k, k, m);
				if (secret_x[i]) begin
					k = mul_mod(k, c1, m);
				end
			end
		end
		res.key = k[31:0];
		if (k == 0) begin
			res.no_inv = 1'b1;
			return res;
		end
		// Extended Euclid with the coefficient kept modulo m.
		r0 = m; r1 = k; t0 = 0; t1 = 1;
		while (r1 != 0) begin
			qt = r0 / r1;
			nr = r0 - qt * r1;
			nt = (t0 + m - mul_mod(qt % m, t1, m)) % m;
			r0 = r1; r1 = nr; t0 = t1; t1 = nt;
		end
		if (r0 != 1) begin
			res.no_inv = 1'b1;
		end else begin
			pt = mul_mod(c2, t0, m);
			res.plain = pt[31:0];
		end
		return res;
	endfunction

	function void note_input(logic [31:0] c1, logic [31:0] c2);
		pending_results.push_back(decrypt(c1, c2));
	endfunction

	function void check_result(logic [31:0] plain, logic [31:0] key, logic no_inv);
		decrypt_result_t exp_res;
		checked_count++;
		if (no_inv) begin
			no_inverse_seen++;
		end
		if (pending_results.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= 10) begin
				$display("Unexpected item: plaintext=%h key=%h no_inverse=%b", plain, key, no_inv);
			end
			return;
		end
		exp_res = pending_results.pop_front();
		if (exp_res.plain !== plain || exp_res.key !== key || exp_res.no_inv !== no_inv) begin
			mismatch_count++;
			if (mismatch_count <= 10) begin
				$display("Mismatch: expected plaintext=%h key=%h no_inverse=%b, got %h %h %b",
					exp_res.plain, exp_res.key, exp_res.no_inv, plain, key, no_inv);
			end
		end
	endfunction
endclass

module tb_elgamal_decrypt_core;
	import eld_pkg::*;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [31:0]               cfg_data;
	logic                      in_valid;
	logic                      in_ready;
	logic [31:0]               cipher_first;
	logic [31:0]               cipher_second;
	logic                      out_valid;
	logic                      out_ready;
	logic [31:0]               plaintext;
	logic [31:0]               shared_key;
	logic                      no_inverse;

	decrypt_scoreboard scoreboard;
	int                items_sent;
	int                phases_run;

	elgamal_decrypt_core #(.WORD_BITS(32)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.cipher_first(cipher_first), .cipher_second(cipher_second),
		.out_valid(out_valid), .out_ready(out_ready),
		.plaintext(plaintext), .shared_key(shared_key), .no_inverse(no_inverse)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Run limit: room for about 270 items of the longest kind, several times over.
	initial begin
		#40_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// Receiver: random stalls before each item, and checks at the accepting edge.
	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			scoreboard.check_result(plaintext, shared_key, no_inverse);
		end
	end

	// Sends one ciphertext item after a random gap and records its expectation.
	task automatic send_cipher(input logic [31:0] c1, input logic [31:0] c2);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cipher_first <= c1;
		cipher_second <= c2;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		scoreboard.note_input(c1, c2);
		items_sent++;
	endtask

	// Waits until every expected item has returned and the core has settled.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (scoreboard.pending_results.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	// Writes one register while the core is idle and updates the prediction.
	task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		if (idx == REG_MODULUS) begin
			scoreboard.modulus_q = val;
		end else begin
			scoreboard.secret_x = val;
		end
	endtask

	task automatic set_registers(input logic [31:0] q, input logic [31:0] x);
		drain_results();
		write_register(REG_MODULUS, q);
		write_register(REG_PRIVATE_KEY, x);
		cfg_we <= 1'b0;
		phases_run++;
	endtask

	// Random ciphertexts, mostly reduced values with some raw full-range words and multiples of the modulus.
	task automatic random_ciphers(input int count);
		logic [31:0] q, c1, c2;
		q = scoreboard.modulus_q;
		for (int i = 0; i < count; i++) begin
			c1 = $urandom();
			c2 = $urandom();
			if (q >= 2 && $urandom_range(0, 3) != 0) begin
				c1 = c1 % q;
				c2 = c2 % q;
			end
			if ($urandom_range(0, 15) == 0) begin
				c1 = (q >= 2) ? q * $urandom_range(0, 2) : 32'd0;
			end
			send_cipher(c1, c2);
		end
	endtask

	// Stimulus.
	initial begin
		logic [31:0] primes [6];
		scoreboard = new();
		items_sent = 0;
		phases_run = 0;
		primes = '{32'hFFFF_FFFB, 32'd65537, 32'd101, 32'd3, 32'h7FFF_FFFF, 32'd1_000_003};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_MODULUS;
		cfg_data = '0;
		in_valid = 1'b0;
		cipher_first = '0;
		cipher_second = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values: modulus two and exponent zero.
		send_cipher(32'd0, 32'd1);
		send_cipher(32'd1, 32'd1);
		send_cipher(32'hFFFF_FFFF, 32'hFFFF_FFFF);

		// Modulus below two gives a flagged zero result.
		set_registers(32'd0, 32'd5);
		send_cipher(32'd7, 32'd9);
		set_registers(32'd1, 32'hFFFF_FFFF);
		send_cipher(32'hFFFF_FFFF, 32'd3);

		// Largest 32-bit prime with extreme exponents and fields.
		set_registers(32'hFFFF_FFFB, 32'hFFFF_FFFF);
		send_cipher(32'd0, 32'd12345);
		send_cipher(32'd1, 32'hFFFF_FFFF);
		send_cipher(32'hFFFF_FFFA, 32'hFFFF_FFFB);
		send_cipher(32'hFFFF_FFFF, 32'hAAAA_5555);
		set_registers(32'hFFFF_FFFB, 32'd0);
		send_cipher(32'd0, 32'd5);
		send_cipher(32'h5555_AAAA, 32'd77);

		// Composite modulus with keys that share a factor.
		set_registers(32'd12, 32'd1);
		send_cipher(32'd6, 32'd5);
		send_cipher(32'd5, 32'd7);
		send_cipher(32'd13, 32'd11);
		set_registers(32'hFFFF_FFFF, 32'd3);
		send_cipher(32'd3, 32'd1);
		send_cipher(32'hFFFF_FFFE, 32'd2);

		// Random phases over assorted moduli and exponents.
		for (int p = 0; p < 12; p++) begin
			logic [31:0] q;
			case ($urandom_range(0, 3))
				0: q = primes[$urandom_range(0, 5)];
				1: q = $urandom_range(2, 1000);
				2: q = $urandom() | 32'h8000_0000;
				default: q = $urandom_range(2, 40);
			endcase
			set_registers(q, ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom());
			random_ciphers(21);
		end

		drain_results();
		$display("Covered %0d items over %0d register settings; %0d had no inverse.",
			items_sent, phases_run, scoreboard.no_inverse_seen);
		if (scoreboard.mismatch_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Mismatches: %0d", scoreboard.mismatch_count);
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

/* sim.f */
design/eld_pkg.sv
design/eld_dp.sv
design/eld_ctrl.sv
design/elgamal_decrypt_core.sv
design/eld_checker.sv
verif/tb_elgamal_decrypt_core.sv
